@@ sv/asas_pkg.sv @@
// Shared widths, request codes and stage/result types for the ADC scan sequencer.
package asas_pkg;

    localparam int unsigned CH_W        = 3;
    localparam int unsigned SMP_W       = 10;
    localparam int unsigned AVG_W       = 10;
    localparam int unsigned SUM_W       = 16;
    localparam int unsigned CNT_W       = 6;
    localparam int unsigned MASK_W      = 8;
    localparam int unsigned TABLE_DEPTH = 8;
    localparam int unsigned RECIP_W     = 18;
    localparam int unsigned OUTQ_DEPTH  = 4;
    localparam int unsigned OQ_PTR_W    = 2;
    localparam int unsigned OQ_CNT_W    = 3;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Item in flight between acceptance and the result queue
    typedef struct packed {
        logic             req;
        logic             done;
        logic [CH_W-1:0]  fin;
        logic [CH_W-1:0]  scan;
        logic [SUM_W-1:0] sum;
    } t_stage;

    // Finished result item
    typedef struct packed {
        logic [CH_W-1:0]  scan;
        logic             avg_ready;
        logic [CH_W-1:0]  fin;
        logic [AVG_W-1:0] avg;
        logic [AVG_W-1:0] rval;
    } t_result;

endpackage

@@ sv/asas_accum.sv @@
// Sample accumulator, sample counter and next-enabled-channel pick.
module asas_accum #(
    parameter int unsigned SAMPLES_PER_AVERAGE = 8,
    parameter int unsigned CHANNELS            = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_req_type,
    input  logic [asas_pkg::SMP_W-1:0]  i_sample,
    input  logic [asas_pkg::MASK_W-1:0] i_enable_mask,
    output asas_pkg::t_stage            o_stage
);
    import asas_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CH_W-1:0]  r_chan, n_chan;

    logic [CNT_W:0]   cnt_inc;
    logic [SUM_W-1:0] sum_add;
    logic             done;
    logic [CH_W-1:0]  next_ch;

    // First enabled channel after cur, wrapping; hold cur if none
    function automatic logic [CH_W-1:0] pick_next(input logic [CH_W-1:0] cur,
                                                  input logic [MASK_W-1:0] mask);
        logic            found;
        logic [CH_W:0]   c;
        logic [CH_W-1:0] res;
        found = 1'b0;
        res   = cur;
        for (int k = 1; k <= CHANNELS; k++) begin
            c = (CH_W+1)'(cur) + (CH_W+1)'(k);
            if (c >= (CH_W+1)'(CHANNELS)) begin
                c = c - (CH_W+1)'(CHANNELS);
            end
            if (!found && mask[c[CH_W-1:0]]) begin
                res   = c[CH_W-1:0];
                found = 1'b1;
            end
        end
        return res;
    endfunction

    always_comb begin
        cnt_inc = (CNT_W+1)'(r_count) + (CNT_W+1)'(1);
        sum_add = r_sum + SUM_W'(i_sample);
        done    = (i_req_type == REQ_SAMPLE) &&
                  (cnt_inc >= (CNT_W+1)'(SAMPLES_PER_AVERAGE));
        next_ch = pick_next(r_chan, i_enable_mask);

        o_stage.req  = i_req_type;
        o_stage.done = done;
        o_stage.fin  = r_chan;
        o_stage.scan = done ? next_ch : r_chan;
        o_stage.sum  = sum_add;

        n_count = r_count;
        n_sum   = r_sum;
        n_chan  = r_chan;
        if (i_accept && i_req_type == REQ_SAMPLE) begin
            if (done) begin
                n_count = '0;
                n_sum   = '0;
                n_chan  = next_ch;
            end else begin
                n_count = cnt_inc[CNT_W-1:0];
                n_sum   = sum_add;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_chan  <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_chan  <= n_chan;
        end
    end

endmodule

@@ sv/asas_table.sv @@
// Eight-entry average table: synchronous memory, valid bits, write-to-read forwarding.
module asas_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [asas_pkg::CH_W-1:0]  i_rd_addr,
    input  logic                       i_wr_en,
    input  logic [asas_pkg::CH_W-1:0]  i_wr_addr,
    input  logic [asas_pkg::AVG_W-1:0] i_wr_data,
    output logic [asas_pkg::AVG_W-1:0] o_rd_data
);
    import asas_pkg::*;

    logic [AVG_W-1:0]       mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [AVG_W-1:0]       r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Forward a same-cycle write; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && i_wr_addr == i_rd_addr) begin
                r_rd_data <= i_wr_data;
            end else if (r_valid[i_rd_addr]) begin
                r_rd_data <= mem[i_rd_addr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/asas_outq.sv @@
// Four-entry result queue between the table stage and the output channel.
module asas_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  asas_pkg::t_result             i_data,
    input  logic                          i_pop,
    output logic                          o_valid,
    output asas_pkg::t_result             o_data,
    output logic [asas_pkg::OQ_CNT_W-1:0] o_count
);
    import asas_pkg::*;

    t_result               mem [OUTQ_DEPTH];
    logic [OQ_PTR_W-1:0]   r_wptr, r_rptr;
    logic [OQ_CNT_W-1:0]   r_count, n_count;
    logic                  do_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = mem[r_rptr];
    assign o_count = r_count;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + OQ_CNT_W'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - OQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + OQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + OQ_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

@@ sv/adc_scan_averaging_sequencer.sv @@
// Top level of the ADC round-robin scan sequencer with per-channel averaging.
//
// Input channel (i_in_valid / o_in_stall) carries one item per accepted edge:
// either a converter sample for the channel being scanned, or a read request
// for the stored average of i_read_channel. Output channel (o_out_valid /
// i_out_stall) returns exactly one result item per input item, in order.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes the
// enable mask; it must be written only while the block is idle (unchecked).
//
// An accepted item is registered in stage one and then pushed into the queue.
// Throughput: one item per cycle; the accumulator and channel pick settle in
// the accepting cycle, the average division (a reciprocal multiply) and the
// table write happen in the following stage, and table reads are forwarded.
// A stalled receiver holds its result while a four-entry queue keeps taking
// items; o_in_stall rises once queue plus stage hold four items.
//
// Reset: sum, count and scan channel clear, the scan starts at channel 0,
// the enable mask returns to all ones and every table entry reads as zero.
module adc_scan_averaging_sequencer #(
    parameter int unsigned SAMPLES_PER_AVERAGE = 8,
    parameter int unsigned CHANNELS            = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input items
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_req_type,
    input  logic [asas_pkg::SMP_W-1:0]  i_sample,
    input  logic [asas_pkg::CH_W-1:0]   i_read_channel,
    // result items
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [asas_pkg::CH_W-1:0]   o_scan_channel,
    output logic                        o_average_ready,
    output logic [asas_pkg::CH_W-1:0]   o_finished_channel,
    output logic [asas_pkg::AVG_W-1:0]  o_average_value,
    output logic [asas_pkg::AVG_W-1:0]  o_read_value,
    // enable mask write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [asas_pkg::MASK_W-1:0] i_cfg_data
);
    import asas_pkg::*;

    // Divide by SAMPLES_PER_AVERAGE as multiply by a rounded-up reciprocal;
    // the shift is wide enough that the quotient is exact for any 16-bit sum.
    localparam int unsigned DIV_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam longint unsigned RECIP_L =
        ((64'd1 << DIV_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int unsigned PROD_W = SUM_W + RECIP_W;

    logic [MASK_W-1:0] r_mask;
    logic              accept;
    t_stage            acc_stage;
    logic              r_s1_valid;
    t_stage            r_s1;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    logic [AVG_W-1:0]  avg;
    logic [AVG_W-1:0]  rd_data;
    logic              tbl_wr;
    t_result           s1_res;
    logic [OQ_CNT_W-1:0] oq_count;
    t_result           oq_data;

    // Stall once the stage plus queue could overrun the queue
    assign o_in_stall = (OQ_CNT_W'(r_s1_valid) + oq_count) >= OQ_CNT_W'(OUTQ_DEPTH);
    assign accept     = i_in_valid && !o_in_stall;

    // Enable mask register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mask <= i_cfg_data;
        end
    end

    asas_accum #(
        .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE),
        .CHANNELS           (CHANNELS)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .i_sample     (i_sample),
        .i_enable_mask(r_mask),
        .o_stage      (acc_stage)
    );

    // Stage one: hold the accepted item while the table read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= acc_stage;
        end
    end

    always_comb begin
        prod = PROD_W'(r_s1.sum) * PROD_W'(RECIP);
        quot = prod >> DIV_SHIFT;
        avg  = r_s1.done ? quot[AVG_W-1:0] : '0;
    end

    assign tbl_wr = r_s1_valid && r_s1.done;

    asas_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept && i_req_type == REQ_READ),
        .i_rd_addr(i_read_channel),
        .i_wr_en  (tbl_wr),
        .i_wr_addr(r_s1.fin),
        .i_wr_data(avg),
        .o_rd_data(rd_data)
    );

    // Assemble the result; fields that do not apply read as zero
    always_comb begin
        s1_res.scan      = r_s1.scan;
        s1_res.avg_ready = r_s1.done;
        s1_res.fin       = r_s1.done ? r_s1.fin : '0;
        s1_res.avg       = avg;
        s1_res.rval      = (r_s1.req == REQ_READ) ? rd_data : '0;
    end

    asas_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (r_s1_valid),
        .i_data (s1_res),
        .i_pop  (!i_out_stall),
        .o_valid(o_out_valid),
        .o_data (oq_data),
        .o_count(oq_count)
    );

    assign o_scan_channel     = oq_data.scan;
    assign o_average_ready    = oq_data.avg_ready;
    assign o_finished_channel = oq_data.fin;
    assign o_average_value    = oq_data.avg;
    assign o_read_value       = oq_data.rval;

endmodule

@@ sv/asas_checker.sv @@
// Port-level assertions for the scan sequencer, bound to the top level.
module asas_checker #(
    parameter int unsigned CHANNELS = 8
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [asas_pkg::CH_W-1:0]  o_scan_channel,
    input logic                       o_average_ready,
    input logic [asas_pkg::CH_W-1:0]  o_finished_channel,
    input logic [asas_pkg::AVG_W-1:0] o_average_value,
    input logic [asas_pkg::AVG_W-1:0] o_read_value
);
    import asas_pkg::*;

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped under stall");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_average_value) &&
            $stable(o_read_value) && $stable(o_scan_channel))
        else $error("result payload changed under stall");

    // No completed average: completion fields read zero
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_average_ready |->
            o_finished_channel == '0 && o_average_value == '0)
        else $error("completion fields set without a stored average");

    // A read never completes an average
    a_read_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_value != '0 |-> !o_average_ready)
        else $error("read result flagged as completed average");

    // The scan never leaves the configured channel range
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CH_W+1)'(o_scan_channel) < (CH_W+1)'(CHANNELS))
        else $error("scan channel out of range");

endmodule

bind adc_scan_averaging_sequencer asas_checker #(.CHANNELS(CHANNELS)) u_asas_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_scan_channel    (o_scan_channel),
    .o_average_ready   (o_average_ready),
    .o_finished_channel(o_finished_channel),
    .o_average_value   (o_average_value),
    .o_read_value      (o_read_value)
);
